[sv/afc3_pkg.sv]
`default_nettype none

package afc3_pkg;

    // fixed field widths
    localparam int DATA_W   = 32;
    localparam int GAIN_W   = 31;
    localparam int STEP_W   = 24;
    localparam int STEP_BITS = 24;
    localparam int CNT_W    = $clog2(GAIN_W);
    localparam int CFG_IDX_W = 3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_INV_MASS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DAMPING   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STIFFNESS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ACC_LIM   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_VEL_LIM   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_POS_LIM   = 3'd6;

    // multiply phases of one item
    localparam logic [2:0] PH_DAMP = 3'd0;
    localparam logic [2:0] PH_STIF = 3'd1;
    localparam logic [2:0] PH_ACC  = 3'd2;
    localparam logic [2:0] PH_VEL  = 3'd3;
    localparam logic [2:0] PH_POS  = 3'd4;

    typedef struct packed {
        logic [GAIN_W-1:0] inverse_mass;
        logic [GAIN_W-1:0] damping_gain;
        logic [GAIN_W-1:0] stiffness_gain;
        logic [STEP_W-1:0] step_size;
        logic [GAIN_W-1:0] accel_limit;
        logic [GAIN_W-1:0] vel_limit;
        logic [GAIN_W-1:0] pos_limit;
    } t_cfg;

    typedef struct packed {
        logic       take;
        logic       load;
        logic       shift;
        logic       commit;
        logic [2:0] phase;
    } t_ctrl;

    // saturate to the signed 32-bit range
    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] v);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = 64'sh0000_0000_7FFF_FFFF;
        lo = -64'sh0000_0000_8000_0000;
        if (v > hi) begin
            sat32 = 32'sh7FFF_FFFF;
        end else if (v < lo) begin
            sat32 = 32'sh8000_0000;
        end else begin
            sat32 = v[DATA_W-1:0];
        end
    endfunction

    // upper clamp only
    function automatic logic signed [DATA_W-1:0] clamp_hi(
        input logic signed [DATA_W-1:0] x,
        input logic [GAIN_W-1:0]        lim
    );
        logic signed [DATA_W-1:0] l;
        l = $signed({1'b0, lim});
        clamp_hi = (x > l) ? l : x;
    endfunction

endpackage

`default_nettype wire

[sv/afc3_mul.sv]
`default_nettype none

module afc3_mul (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_load,
    input  wire logic                                 i_shift,
    input  wire logic [afc3_pkg::GAIN_W-1:0]          i_gain,
    input  wire logic signed [afc3_pkg::DATA_W-1:0]   i_x,
    output logic signed [63:0]                        o_prod
);

    logic [afc3_pkg::GAIN_W-1:0]        r_gain;
    logic signed [afc3_pkg::DATA_W-1:0] r_x;
    logic signed [32:0]                 r_hi;
    logic [afc3_pkg::GAIN_W-1:0]        r_lo;
    logic signed [33:0]                 n_sum;

    // one multiplier bit per cycle while i_shift is high, lsb first
    always_comb begin
        n_sum = 34'(r_hi) + (r_gain[0] ? 34'(r_x) : 34'sd0);
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_gain <= i_gain;
            r_x    <= i_x;
            r_hi   <= '0;
            r_lo   <= '0;
        end else if (i_shift) begin
            r_gain <= {1'b0, r_gain[afc3_pkg::GAIN_W-1:1]};
            r_hi   <= n_sum[33:1];
            r_lo   <= {n_sum[0], r_lo[afc3_pkg::GAIN_W-1:1]};
        end
    end

    assign o_prod = {r_hi, r_lo};

endmodule

`default_nettype wire

[sv/afc3_lane.sv]
`default_nettype none

module afc3_lane #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire afc3_pkg::t_ctrl                      i_ctrl,
    input  wire afc3_pkg::t_cfg                       i_cfg,
    input  wire logic signed [afc3_pkg::DATA_W-1:0]   i_desired,
    input  wire logic signed [afc3_pkg::DATA_W-1:0]   i_measured,
    output logic signed [afc3_pkg::DATA_W-1:0]        o_accel,
    output logic signed [afc3_pkg::DATA_W-1:0]        o_velocity,
    output logic signed [afc3_pkg::DATA_W-1:0]        o_position
);

    localparam int NW = 66 - FRAC_BITS;

    logic signed [NW-1:0]               r_net;
    logic signed [afc3_pkg::DATA_W-1:0] r_acc;
    logic signed [afc3_pkg::DATA_W-1:0] r_vi;
    logic signed [afc3_pkg::DATA_W-1:0] r_pi;
    logic signed [afc3_pkg::DATA_W-1:0] r_vfb;
    logic signed [afc3_pkg::DATA_W-1:0] r_pfb;

    logic [afc3_pkg::GAIN_W-1:0]        n_gain;
    logic signed [afc3_pkg::DATA_W-1:0] n_x;
    logic signed [63:0]                 prod;
    logic signed [63:0]                 p_frac;
    logic signed [63:0]                 p_step;
    logic signed [afc3_pkg::DATA_W-1:0] n_vel;
    logic signed [afc3_pkg::DATA_W-1:0] n_pos;

    // operand select per phase
    always_comb begin
        case (i_ctrl.phase)
            afc3_pkg::PH_DAMP: begin
                n_gain = i_cfg.damping_gain;
                n_x    = r_vfb;
            end
            afc3_pkg::PH_STIF: begin
                n_gain = i_cfg.stiffness_gain;
                n_x    = r_pfb;
            end
            afc3_pkg::PH_ACC: begin
                n_gain = i_cfg.inverse_mass;
                n_x    = afc3_pkg::sat32(64'(r_net));
            end
            afc3_pkg::PH_VEL: begin
                n_gain = afc3_pkg::GAIN_W'(i_cfg.step_size);
                n_x    = r_acc;
            end
            afc3_pkg::PH_POS: begin
                n_gain = afc3_pkg::GAIN_W'(i_cfg.step_size);
                n_x    = r_vi;
            end
            default: begin
                n_gain = '0;
                n_x    = '0;
            end
        endcase
    end

    afc3_mul u_mul (
        .i_clk   (i_clk),
        .i_load  (i_ctrl.load),
        .i_shift (i_ctrl.shift),
        .i_gain  (n_gain),
        .i_x     (n_x),
        .o_prod  (prod)
    );

    // floor shifts of the full product
    assign p_frac = prod >>> FRAC_BITS;
    assign p_step = prod >>> afc3_pkg::STEP_BITS;
    assign n_vel  = afc3_pkg::sat32(64'(r_vi) + p_step);
    assign n_pos  = afc3_pkg::sat32(64'(r_pi) + p_step);

    // net force and acceleration
    always_ff @(posedge i_clk) begin
        if (i_ctrl.take) begin
            r_net <= NW'(i_measured) - NW'(i_desired);
        end else if (i_ctrl.commit) begin
            case (i_ctrl.phase)
                afc3_pkg::PH_DAMP: r_net <= r_net - p_frac[NW-1:0];
                afc3_pkg::PH_STIF: r_net <= r_net - p_frac[NW-1:0];
                afc3_pkg::PH_ACC:  r_acc <= afc3_pkg::sat32(p_frac);
                afc3_pkg::PH_POS:  r_acc <= afc3_pkg::clamp_hi(r_acc, i_cfg.accel_limit);
                default: ;
            endcase
        end
    end

    // integrators and clamped feedback
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vi  <= '0;
            r_pi  <= '0;
            r_vfb <= '0;
            r_pfb <= '0;
        end else if (i_ctrl.commit) begin
            case (i_ctrl.phase)
                afc3_pkg::PH_VEL: r_vi <= n_vel;
                afc3_pkg::PH_POS: begin
                    r_pi  <= n_pos;
                    r_vfb <= afc3_pkg::clamp_hi(r_vi, i_cfg.vel_limit);
                    r_pfb <= afc3_pkg::clamp_hi(n_pos, i_cfg.pos_limit);
                end
                default: ;
            endcase
        end
    end

    assign o_accel    = r_acc;
    assign o_velocity = r_vfb;
    assign o_position = r_pfb;

endmodule

`default_nettype wire

[sv/afc3_seq.sv]
`default_nettype none

module afc3_seq (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    input  wire logic            i_out_free,
    output afc3_pkg::t_ctrl      o_ctrl,
    output logic                 o_done
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_LOAD   = 3'd1;
    localparam logic [2:0] ST_MUL    = 3'd2;
    localparam logic [2:0] ST_COMMIT = 3'd3;
    localparam logic [2:0] ST_HOLD   = 3'd4;

    logic [2:0]                  r_state;
    logic [2:0]                  n_state;
    logic [2:0]                  r_phase;
    logic [2:0]                  n_phase;
    logic [afc3_pkg::CNT_W-1:0]  r_cnt;
    logic [afc3_pkg::CNT_W-1:0]  n_cnt;

    // phase sequencing: load, bit-serial multiply, commit
    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        n_cnt   = r_cnt;
        o_done  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_LOAD;
                    n_phase = afc3_pkg::PH_DAMP;
                end
            end
            ST_LOAD: begin
                n_state = ST_MUL;
                n_cnt   = '0;
            end
            ST_MUL: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == afc3_pkg::CNT_W'(afc3_pkg::GAIN_W - 1)) begin
                    n_state = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                if (r_phase == afc3_pkg::PH_POS) begin
                    n_state = ST_HOLD;
                end else begin
                    n_state = ST_LOAD;
                    n_phase = r_phase + 1'b1;
                end
            end
            ST_HOLD: begin
                if (i_out_free) begin
                    o_done  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_phase <= afc3_pkg::PH_DAMP;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
        end
    end

    assign o_in_ready     = (r_state == ST_IDLE);
    assign o_ctrl.take    = (r_state == ST_IDLE) && i_in_valid;
    assign o_ctrl.load    = (r_state == ST_LOAD);
    assign o_ctrl.shift   = (r_state == ST_MUL);
    assign o_ctrl.commit  = (r_state == ST_COMMIT);
    assign o_ctrl.phase   = r_phase;

endmodule

`default_nettype wire

[sv/admittance_force_control_3axis.sv]
// Per-axis admittance (mass-spring-damper) controller, one lane per axis.
// Input stream: a word carries desired forces for every axis, then measured
// forces, signed Q16.16, 32 bits each. Output stream: a word carries clamped
// acceleration for every axis, then velocity, then position.
// Configuration channel: register index plus data, always ready; write it only
// while the block is idle.
// Each word runs five bit-serial multiplies per lane (damping, stiffness,
// inverse mass, two step-size integrations), each a load, a shift over the
// 31 gain bits and a commit, with all lanes in parallel. The next word can
// be taken in the cycle after the result enters the output register; no
// new word is taken while one is being computed.
// Reset clears velocity and position state and the feedback, restores the
// register defaults and empties the output register.
// A stalled receiver holds the result in the output register; one more word
// may be taken and computed meanwhile, and it waits until the output frees.
`default_nettype none

module admittance_force_control_3axis #(
    parameter int AXES      = 3,
    parameter int FRAC_BITS = 16
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    // slave stream
    input  wire logic                                  i_s_axis_tvalid,
    output logic                                       o_s_axis_tready,
    // desired_force per axis (x first), then measured_force per axis
    input  wire logic [2*AXES*afc3_pkg::DATA_W-1:0]    i_s_axis_tdata,
    // master stream
    output logic                                       o_m_axis_tvalid,
    input  wire logic                                  i_m_axis_tready,
    // accel per axis (x first), then velocity per axis, then position per axis
    output logic [3*AXES*afc3_pkg::DATA_W-1:0]         o_m_axis_tdata,
    // configuration write channel
    input  wire logic                                  i_cfg_valid,
    output logic                                       o_cfg_ready,
    input  wire logic [afc3_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  wire logic [afc3_pkg::DATA_W-1:0]           i_cfg_data
);

    localparam int DW = afc3_pkg::DATA_W;

    afc3_pkg::t_cfg              r_cfg;
    afc3_pkg::t_ctrl             ctrl;
    logic                        done;
    logic                        out_free;
    logic                        r_out_valid;
    logic [3*AXES*DW-1:0]        r_out_data;
    logic [3*AXES*DW-1:0]        lane_data;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.inverse_mass   <= 31'd131072;
            r_cfg.damping_gain   <= 31'd2949120;
            r_cfg.stiffness_gain <= 31'd655360;
            r_cfg.step_size      <= 24'd67109;
            r_cfg.accel_limit    <= 31'd327680000;
            r_cfg.vel_limit      <= 31'd65536000;
            r_cfg.pos_limit      <= 31'd2621;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                afc3_pkg::CFG_INV_MASS:  r_cfg.inverse_mass   <= i_cfg_data[30:0];
                afc3_pkg::CFG_DAMPING:   r_cfg.damping_gain   <= i_cfg_data[30:0];
                afc3_pkg::CFG_STIFFNESS: r_cfg.stiffness_gain <= i_cfg_data[30:0];
                afc3_pkg::CFG_STEP:      r_cfg.step_size      <= i_cfg_data[23:0];
                afc3_pkg::CFG_ACC_LIM:   r_cfg.accel_limit    <= i_cfg_data[30:0];
                afc3_pkg::CFG_VEL_LIM:   r_cfg.vel_limit      <= i_cfg_data[30:0];
                afc3_pkg::CFG_POS_LIM:   r_cfg.pos_limit      <= i_cfg_data[30:0];
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // sequencer
    assign out_free = !r_out_valid || i_m_axis_tready;

    afc3_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_out_free (out_free),
        .o_ctrl     (ctrl),
        .o_done     (done)
    );

    // one lane per axis
    for (genvar a = 0; a < AXES; a++) begin : g_lane
        afc3_lane #(
            .FRAC_BITS (FRAC_BITS)
        ) u_lane (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctrl     (ctrl),
            .i_cfg      (r_cfg),
            .i_desired  ($signed(i_s_axis_tdata[a*DW +: DW])),
            .i_measured ($signed(i_s_axis_tdata[(AXES+a)*DW +: DW])),
            .o_accel    (lane_data[a*DW +: DW]),
            .o_velocity (lane_data[(AXES+a)*DW +: DW]),
            .o_position (lane_data[(2*AXES+a)*DW +: DW])
        );
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (done) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done) begin
            r_out_data <= lane_data;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

endmodule

`default_nettype wire

[bench/admittance_force_control_3axis_tb.sv]
`timescale 1ns / 1ps

module admittance_force_control_3axis_tb;

    localparam int AXES           = 3;
    localparam int FRAC_BITS      = 16;
    localparam int DW             = afc3_pkg::DATA_W;
    localparam int CYCLE_LIMIT    = 1000000;
    localparam int RX_HOLD_CYCLES = 3000;
    localparam int TAIL_CYCLES    = 400;
    localparam int RAND_PHASES    = 8;
    localparam int RAND_PER_PHASE = 154;

    // index beyond the register file, writes there are dropped
    localparam logic [afc3_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

    // result quantities, lowest first in the output word
    localparam int Q_ACC = 0;
    localparam int Q_VEL = 1;
    localparam int Q_POS = 2;

    localparam logic [DW-1:0] F_MAX = 32'h7FFF_FFFF;
    localparam logic [DW-1:0] F_MIN = 32'h8000_0000;
    localparam logic [DW-1:0] ALL1  = 32'hFFFF_FFFF;

    // one force sample: desired per axis in the low half, measured above
    typedef struct packed {
        logic [AXES-1:0][DW-1:0] measured;
        logic [AXES-1:0][DW-1:0] desired;
    } force_item_t;

    // one motion result: [quantity][axis], accel x in the lowest bits
    typedef logic [2:0][AXES-1:0][DW-1:0] motion_t;

    logic i_clk = 1'b0;
    logic rst_n = 1'b0;

    logic                     s_valid = 1'b0;
    logic [2*AXES*DW-1:0]     s_data  = '0;
    logic                     o_s_axis_tready;
    logic                     o_m_axis_tvalid;
    logic                     m_ready = 1'b0;
    logic [3*AXES*DW-1:0]     o_m_axis_tdata;
    logic                     cfg_valid = 1'b0;
    logic                     o_cfg_ready;
    logic [afc3_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [DW-1:0]            cfg_data = '0;

    admittance_force_control_3axis #(
        .AXES      (AXES),
        .FRAC_BITS (FRAC_BITS)
    ) u_top (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // register mirror, starts at the reset defaults
    afc3_pkg::t_cfg cfg_model = '{
        inverse_mass:   31'd131072,
        damping_gain:   31'd2949120,
        stiffness_gain: 31'd655360,
        step_size:      24'd67109,
        accel_limit:    31'd327680000,
        vel_limit:      31'd65536000,
        pos_limit:      31'd2621
    };

    // plant state per axis
    int vel_fb  [AXES] = '{default: 0};
    int pos_fb  [AXES] = '{default: 0};
    int vel_acc [AXES] = '{default: 0};
    int pos_acc [AXES] = '{default: 0};

    force_item_t pending_forces [$];
    motion_t     expected_motion [$];
    force_item_t offered_force;
    force_item_t last_force = '0;
    motion_t     predicted;
    motion_t     want;

    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    int rx_hold_left = 0;
    logic rx_hold_load = 1'b0;
    int errors      = 0;
    int cycle_count = 0;
    string qty_name [3] = '{"accel", "velocity", "position"};
    string axis_name = "xyz";

    // fixed point helpers
    function automatic longint mul_floor(input longint gain, input int x, input int s);
        return (gain * longint'(x)) >>> s;
    endfunction

    function automatic int saturate32(input longint v);
        if (v > longint'(32'sh7FFF_FFFF)) return 32'sh7FFF_FFFF;
        if (v < -longint'(64'sh8000_0000)) return 32'sh8000_0000;
        return int'(v);
    endfunction

    function automatic int clamp_top(input int x, input logic [30:0] lim);
        int l;
        l = int'({1'b0, lim});
        return (x > l) ? l : x;
    endfunction

    // one control step of all axes, updates the plant state
    task automatic predict_motion(input force_item_t f, output motion_t r);
        longint net;
        int     m;
        int     acc;
        int     vel;
        int     pos;
        for (int a = 0; a < AXES; a++) begin
            net = (longint'($signed(f.measured[a])) - longint'($signed(f.desired[a])))
                - mul_floor({1'b0, cfg_model.damping_gain}, vel_fb[a], FRAC_BITS)
                - mul_floor({1'b0, cfg_model.stiffness_gain}, pos_fb[a], FRAC_BITS);
            m   = saturate32(net);
            acc = saturate32(mul_floor({1'b0, cfg_model.inverse_mass}, m, FRAC_BITS));
            vel = saturate32(longint'(vel_acc[a])
                + mul_floor({8'b0, cfg_model.step_size}, acc, afc3_pkg::STEP_BITS));
            vel_acc[a] = vel;
            pos = saturate32(longint'(pos_acc[a])
                + mul_floor({8'b0, cfg_model.step_size}, vel, afc3_pkg::STEP_BITS));
            pos_acc[a] = pos;
            r[Q_ACC][a] = clamp_top(acc, cfg_model.accel_limit);
            r[Q_VEL][a] = clamp_top(vel, cfg_model.vel_limit);
            r[Q_POS][a] = clamp_top(pos, cfg_model.pos_limit);
            vel_fb[a] = r[Q_VEL][a];
            pos_fb[a] = r[Q_POS][a];
        end
    endtask

    // register write, mirror follows on the handshake
    task automatic cfg_write(input logic [afc3_pkg::CFG_IDX_W-1:0] idx,
                             input logic [DW-1:0] data);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            afc3_pkg::CFG_INV_MASS:  cfg_model.inverse_mass   = data[30:0];
            afc3_pkg::CFG_DAMPING:   cfg_model.damping_gain   = data[30:0];
            afc3_pkg::CFG_STIFFNESS: cfg_model.stiffness_gain = data[30:0];
            afc3_pkg::CFG_STEP:      cfg_model.step_size      = data[23:0];
            afc3_pkg::CFG_ACC_LIM:   cfg_model.accel_limit    = data[30:0];
            afc3_pkg::CFG_VEL_LIM:   cfg_model.vel_limit      = data[30:0];
            afc3_pkg::CFG_POS_LIM:   cfg_model.pos_limit      = data[30:0];
            default: ;
        endcase
        cfg_valid <= 1'b0;
    endtask

    task automatic write_all(input logic [DW-1:0] inv_m, input logic [DW-1:0] damp,
                             input logic [DW-1:0] stiff, input logic [DW-1:0] step,
                             input logic [DW-1:0] alim, input logic [DW-1:0] vlim,
                             input logic [DW-1:0] plim);
        cfg_write(afc3_pkg::CFG_INV_MASS, inv_m);
        cfg_write(afc3_pkg::CFG_DAMPING, damp);
        cfg_write(afc3_pkg::CFG_STIFFNESS, stiff);
        cfg_write(afc3_pkg::CFG_STEP, step);
        cfg_write(afc3_pkg::CFG_ACC_LIM, alim);
        cfg_write(afc3_pkg::CFG_VEL_LIM, vlim);
        cfg_write(afc3_pkg::CFG_POS_LIM, plim);
        @(negedge i_clk);
    endtask

    task automatic push_force(input logic [DW-1:0] dx, input logic [DW-1:0] dy,
                              input logic [DW-1:0] dz, input logic [DW-1:0] mx,
                              input logic [DW-1:0] my, input logic [DW-1:0] mz);
        force_item_t f;
        f.desired  = {dz, dy, dx};
        f.measured = {mz, my, mx};
        pending_forces.push_back(f);
    endtask

    // wait until nothing is queued, offered or outstanding
    task automatic drain();
        @(negedge i_clk);
        while (pending_forces.size() != 0 || s_valid || expected_motion.size() != 0)
            @(negedge i_clk);
    endtask

    function automatic logic [DW-1:0] rand_force();
        case ($urandom_range(0, 7))
            0:       return F_MAX;
            1:       return F_MIN;
            2, 3:    return $urandom();
            default: return $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
        endcase
    endfunction

    // mostly one field changed from the previous sample so the state can build up
    function automatic force_item_t next_force(input force_item_t prev);
        force_item_t f;
        int k;
        f = prev;
        if ($urandom_range(0, 9) < 4) begin
            for (int a = 0; a < AXES; a++) begin
                f.desired[a]  = rand_force();
                f.measured[a] = rand_force();
            end
        end else begin
            k = $urandom_range(0, 2 * AXES - 1);
            if (k < AXES) f.desired[k] = rand_force();
            else f.measured[k - AXES] = rand_force();
        end
        return f;
    endfunction

    function automatic logic [DW-1:0] pick_reg(input logic [DW-1:0] typical);
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return ALL1;
            2:       return $urandom();
            default: return $urandom_range(0, typical);
        endcase
    endfunction

    // receiver hold-off counter
    always @(posedge i_clk) begin
        if (rx_hold_load) begin
            rx_hold_left <= RX_HOLD_CYCLES;
        end else if (rx_hold_left != 0) begin
            rx_hold_left <= rx_hold_left - 1;
        end
    end

    // sample driver
    always @(posedge i_clk) begin
        if (rst_n) begin
            if (s_valid && o_s_axis_tready) begin
                predict_motion(offered_force, predicted);
                expected_motion.push_back(predicted);
            end
            if (!s_valid || o_s_axis_tready) begin
                if (pending_forces.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
                    offered_force = pending_forces.pop_front();
                    s_valid <= 1'b1;
                    s_data  <= offered_force;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (rst_n) begin
            if (o_m_axis_tvalid && m_ready) begin
                if (expected_motion.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result, expected none got %h",
                             $time, o_m_axis_tdata);
                end else begin
                    want = expected_motion.pop_front();
                    for (int q = 0; q < 3; q++) begin
                        for (int a = 0; a < AXES; a++) begin
                            if (o_m_axis_tdata[(q*AXES+a)*DW +: DW] !== want[q][a]) begin
                                errors++;
                                $display("%0t: %s_%c expected %h got %h", $time,
                                         qty_name[q], axis_name[a], want[q][a],
                                         o_m_axis_tdata[(q*AXES+a)*DW +: DW]);
                            end
                        end
                    end
                end
            end
            m_ready <= (rx_hold_left == 0) && ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        repeat (9) @(posedge i_clk);
        rst_n <= 1'b1;
        @(negedge i_clk);

        // reset defaults: zero input, force error extremes, steady pushes
        push_force(0, 0, 0, 0, 0, 0);
        push_force(F_MIN, F_MAX, F_MAX, F_MAX, F_MIN, F_MAX);
        push_force(F_MAX, F_MIN, F_MIN, F_MIN, F_MAX, F_MIN);
        for (int i = 0; i < 4; i++)
            push_force(0, 0, 32'h000A_0000, 32'h000A_0000, 32'h0005_0000, 0);
        push_force(F_MIN, F_MIN, F_MIN, F_MIN, F_MIN, F_MIN);
        drain();

        // zero inverse mass and zero step, masked upper data bit, dropped index
        cfg_write(CFG_UNUSED, ALL1);
        write_all(32'h8000_0000, 32'h802D_0000, 32'h800A_0000, 32'hFF00_0000,
                  32'h9388_0000, 32'h83E8_0000, 32'h8000_0A3D);
        push_force(0, 0, 0, F_MAX, F_MIN, 32'h0001_0000);
        push_force(F_MIN, F_MAX, 0, F_MAX, F_MIN, 0);
        push_force(32'h1234_5678, 0, 0, 0, 0, 0);
        drain();

        // largest gains and step with zero limits
        write_all(ALL1, ALL1, ALL1, ALL1, 0, 0, 0);
        push_force(0, 0, 0, F_MAX, F_MIN, 32'h0000_0001);
        push_force(F_MIN, F_MAX, 0, F_MAX, F_MIN, 32'hFFFF_FFFF);
        push_force(F_MAX, F_MIN, F_MAX, F_MIN, F_MAX, F_MIN);
        push_force(0, 0, 0, 0, 0, 0);
        push_force(F_MAX, F_MAX, F_MAX, F_MIN, F_MIN, F_MIN);
        drain();

        // largest gains with largest limits
        write_all(ALL1, ALL1, ALL1, ALL1, ALL1, ALL1, ALL1);
        push_force(0, 0, 0, F_MAX, F_MIN, F_MAX);
        push_force(0, 0, 0, F_MAX, F_MIN, F_MAX);
        push_force(F_MAX, F_MIN, F_MAX, F_MIN, F_MAX, F_MIN);
        push_force(0, 0, 0, 0, 0, 0);
        push_force(0, 0, 0, 32'h0000_0001, 32'hFFFF_FFFF, 0);
        drain();

        // random settings and samples
        for (int p = 0; p < RAND_PHASES; p++) begin
            if (p == 0) begin
                write_all(32'h0002_0000, 32'h002D_0000, 32'h000A_0000, 32'd67109,
                          32'd327680000, 32'd65536000, 32'h0100_0000);
            end else begin
                if ($urandom_range(0, 1)) cfg_write(CFG_UNUSED, $urandom());
                write_all(pick_reg(32'h0008_0000), pick_reg(32'h0080_0000),
                          pick_reg(32'h0080_0000), pick_reg(32'h0002_0000),
                          pick_reg(32'h1000_0000), pick_reg(32'h1000_0000),
                          pick_reg(32'h1000_0000));
            end
            case (p % 4)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 86; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 86; end
                default: begin tx_idle_pct = 8; rx_stall_pct = 8; end
            endcase
            for (int i = 0; i < RAND_PER_PHASE; i++) begin
                last_force = next_force(last_force);
                pending_forces.push_back(last_force);
                // sender pauses midway until all results are back
                if (p == 5 && i == RAND_PER_PHASE / 2) drain();
            end
            // receiver holds off long enough to back up the input
            if (p == 2) begin
                @(posedge i_clk);
                rx_hold_load <= 1'b1;
                @(posedge i_clk);
                rx_hold_load <= 1'b0;
            end
            drain();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
